// File: src/sndx_pkg.sv
`default_nettype none

package sndx_pkg;

   // Longest name prefix that is looked at; later bytes are dropped.
   localparam int MAX_NAME_CHARS = 15;
   localparam int CHARS_W = $clog2(MAX_NAME_CHARS + 1);

   // Depth of the queue between the classifier and the encoder.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Digit codes: none (vowel, y, other) and the uncoded h/w.
   localparam logic [2:0] CODE_NONE = 3'd0;
   localparam logic [2:0] CODE_SKIP = 3'd7;

   // One name byte after classification.
   typedef struct packed {
      logic       last;
      logic       is_zero;
      logic       is_blank;
      logic       is_stop;
      logic       is_letter;
      logic [2:0] code;
      logic [6:0] upper;
   } class_type;

   // Queue head as seen by the encoder.
   typedef struct packed {
      logic      valid;
      class_type item;
   } qhead_type;

endpackage

`default_nettype wire

// File: src/sndx_front.sv
`default_nettype none

module sndx_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           req_char_code,
   input  wire logic                 req_last,
   input  wire logic                 push,
   output logic                      full,
   output sndx_pkg::qhead_type       head,
   input  wire logic                 take
);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   function automatic logic [2:0] code_of(input logic [7:0] c);
      logic [2:0] r;
      case (c)
         8'h62, 8'h66, 8'h70, 8'h76: r = 3'd1;
         8'h63, 8'h73, 8'h67, 8'h6A, 8'h6B, 8'h71, 8'h78, 8'h7A, 8'h9A, 8'hE7: r = 3'd2;
         8'h64, 8'h74: r = 3'd3;
         8'h6C: r = 3'd4;
         8'h6D, 8'h6E, 8'hF1: r = 3'd5;
         8'h72: r = 3'd6;
         8'h68, 8'h77: r = sndx_pkg::CODE_SKIP;
         default: r = sndx_pkg::CODE_NONE;
      endcase
      return r;
   endfunction

   sndx_pkg::class_type              cls;
   sndx_pkg::class_type              store_ff [sndx_pkg::QUEUE_DEPTH];
   logic [sndx_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sndx_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sndx_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic [7:0]                       folded;
   logic                             accept;

   always_comb begin
      if (req_char_code >= CH_UP_A && req_char_code <= CH_UP_Z) begin
         folded = req_char_code + CASE_GAP;
      end else begin
         folded = req_char_code;
      end
      cls.last      = req_last;
      cls.is_zero   = (req_char_code == 8'h00);
      cls.is_blank  = (folded == CH_SPACE);
      cls.is_stop   = (folded == CH_COMMA) || (folded == CH_HYPHEN);
      cls.is_letter = (folded >= CH_LO_A) && (folded <= CH_LO_Z);
      cls.code      = code_of(folded);
      cls.upper     = 7'(folded - CASE_GAP);
   end

   assign full   = (count_ff == sndx_pkg::QCNT_W'(sndx_pkg::QUEUE_DEPTH));
   assign accept = push && !full;

   assign head.valid = (count_ff != '0);
   assign head.item  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == sndx_pkg::QPTR_W'(sndx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == sndx_pkg::QPTR_W'(sndx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[wr_ptr_ff] <= cls;
      end
   end

`ifndef SYNTHESIS
   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      take |-> count_ff != '0)
      else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sndx_pkg::QCNT_W'(sndx_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

// File: src/sndx_back.sv
`default_nettype none

module sndx_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sndx_pkg::qhead_type  head,
   output logic                      take,
   output logic                      empty,
   input  wire logic                 pop,
   output logic [6:0]                rsp_code_char0,
   output logic [6:0]                rsp_code_char1,
   output logic [6:0]                rsp_code_char2,
   output logic [6:0]                rsp_code_char3,
   output logic                      rsp_bad_name
);

   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_E     = 7'h45;
   localparam logic [6:0] CH_R     = 7'h72;
   localparam logic [6:0] CH_BLANK = 7'h20;
   localparam logic [2:0] DIGITS_DONE = 3'd4;

   logic [2:0]                    codes_ff, codes_in;
   logic [sndx_pkg::CHARS_W-1:0]  chars_ff, chars_in;
   logic [2:0]                    prev_ff, prev_in;
   logic                          ended_ff, ended_in;
   logic                          err_ff, err_in;
   logic [6:0]                    lead_ff, lead_in;
   logic [2:0]                    digit_ff [3];
   logic [2:0]                    digit_in [3];
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [6:0]                    out0_ff, out1_ff, out2_ff, out3_ff;
   logic [6:0]                    out0_in, out1_in, out2_in, out3_in;
   logic                          bad_ff, bad_in;
   logic                          pop_ok;
   sndx_pkg::class_type           it;

   assign it     = head.item;
   assign pop_ok = pop && rsp_valid_ff;
   // A final beat needs the result register free, or freed in this cycle.
   assign take   = head.valid && (!it.last || !rsp_valid_ff || pop_ok);
   assign empty  = !rsp_valid_ff;

   always_comb begin
      codes_in = codes_ff;
      chars_in = chars_ff;
      prev_in  = prev_ff;
      ended_in = ended_ff;
      err_in   = err_ff;
      lead_in  = lead_ff;
      digit_in = digit_ff;
      if (!ended_ff && chars_ff < sndx_pkg::CHARS_W'(sndx_pkg::MAX_NAME_CHARS)) begin
         if (it.is_zero) begin
            ended_in = 1'b1;
         end else begin
            chars_in = chars_ff + 1'b1;
            if (it.is_blank) begin
               ended_in = ended_ff;
            end else if (it.is_stop) begin
               ended_in = 1'b1;
            end else if (codes_ff == 3'd0 && !it.is_letter) begin
               err_in   = 1'b1;
               ended_in = 1'b1;
            end else begin
               if (codes_ff == 3'd0) begin
                  lead_in  = it.upper;
                  codes_in = 3'd1;
               end else if (it.code != sndx_pkg::CODE_NONE &&
                            it.code != sndx_pkg::CODE_SKIP && it.code != prev_ff) begin
                  digit_in[2'(codes_ff - 3'd1)] = it.code;
                  codes_in = codes_ff + 3'd1;
                  if (codes_in == DIGITS_DONE) begin
                     ended_in = 1'b1;
                  end
               end
               // h and w leave the previous code in place.
               if (it.code != sndx_pkg::CODE_SKIP) begin
                  prev_in = it.code;
               end
            end
         end
      end

      if (err_in || chars_in == '0) begin
         out0_in = CH_E;
         out1_in = CH_R;
         out2_in = CH_R;
         out3_in = CH_BLANK;
         bad_in  = 1'b1;
      end else begin
         out0_in = (codes_in != 3'd0) ? lead_in : CH_ZERO;
         out1_in = CH_ZERO + 7'(digit_in[0]);
         out2_in = CH_ZERO + 7'(digit_in[1]);
         out3_in = CH_ZERO + 7'(digit_in[2]);
         bad_in  = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !pop_ok;
      if (take && it.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff     <= '0;
         chars_ff     <= '0;
         prev_ff      <= sndx_pkg::CODE_NONE;
         ended_ff     <= 1'b0;
         err_ff       <= 1'b0;
         lead_ff      <= CH_ZERO;
         digit_ff     <= '{default: 3'd0};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take && it.last) begin
            // The name is done: start the next one from the reset state.
            codes_ff <= '0;
            chars_ff <= '0;
            prev_ff  <= sndx_pkg::CODE_NONE;
            ended_ff <= 1'b0;
            err_ff   <= 1'b0;
            lead_ff  <= CH_ZERO;
            digit_ff <= '{default: 3'd0};
         end else if (take) begin
            codes_ff <= codes_in;
            chars_ff <= chars_in;
            prev_ff  <= prev_in;
            ended_ff <= ended_in;
            err_ff   <= err_in;
            lead_ff  <= lead_in;
            digit_ff <= digit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && it.last) begin
         out0_ff <= out0_in;
         out1_ff <= out1_in;
         out2_ff <= out2_in;
         out3_ff <= out3_in;
         bad_ff  <= bad_in;
      end
   end

   assign rsp_code_char0 = out0_ff;
   assign rsp_code_char1 = out1_ff;
   assign rsp_code_char2 = out2_ff;
   assign rsp_code_char3 = out3_ff;
   assign rsp_bad_name   = bad_ff;

`ifndef SYNTHESIS
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !pop |=> rsp_valid_ff && $stable(out0_ff) && $stable(bad_ff))
      else $error("waiting result lost or changed");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take && it.last |=> codes_ff == '0 && chars_ff == '0 && !ended_ff && !err_ff)
      else $error("name state not cleared after final beat");
   a_counts_bound: assert property (@(posedge clock) disable iff (reset)
      codes_ff <= DIGITS_DONE &&
      chars_ff <= sndx_pkg::CHARS_W'(sndx_pkg::MAX_NAME_CHARS))
      else $error("code or character count out of range");
`endif

endmodule

`default_nettype wire

// File: src/soundex_name_encoder.sv
// Codes leave the encoder through a result register onto the rsp_ ports.
// Throughput: one name byte per cycle, save where a final beat waits on a pop
// of the result; encoder state (previous code, code count) updates per byte.
// A four-entry queue separates byte classification from encoding.
// Reset (synchronous, active high) empties the queue and result register and
// returns the name state to its start values; there is no clearing pass.
`default_nettype none

module soundex_name_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_last,
   input  wire logic        push,
   output logic             full,
   output logic [6:0]       rsp_code_char0,
   output logic [6:0]       rsp_code_char1,
   output logic [6:0]       rsp_code_char2,
   output logic [6:0]       rsp_code_char3,
   output logic             rsp_bad_name,
   output logic             empty,
   input  wire logic        pop
);

   sndx_pkg::qhead_type head;
   logic                take;

   sndx_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .req_last      (req_last),
      .push          (push),
      .full          (full),
      .head          (head),
      .take          (take)
   );

   sndx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .take           (take),
      .empty          (empty),
      .pop            (pop),
      .rsp_code_char0 (rsp_code_char0),
      .rsp_code_char1 (rsp_code_char1),
      .rsp_code_char2 (rsp_code_char2),
      .rsp_code_char3 (rsp_code_char3),
      .rsp_bad_name   (rsp_bad_name)
   );

endmodule

`default_nettype wire

// File: tb/sv/tb_soundex_name_encoder.sv
`default_nettype none

module tb_soundex_name_encoder;

   typedef struct packed {
      logic [6:0] c0;
      logic [6:0] c1;
      logic [6:0] c2;
      logic [6:0] c3;
      logic       bad;
   } soundex_type;

   typedef struct packed {
      logic [7:0]  ch;
      logic        fin;
      logic        typed;
      soundex_type res;
   } dir_row_type;

   localparam soundex_type NAME_ERROR = '{7'("E"), 7'("r"), 7'("r"), 7'(" "), 1'b1};
   localparam soundex_type NAME_BLANK = '{7'("0"), 7'("0"), 7'("0"), 7'("0"), 1'b0};
   localparam soundex_type NO_CODE    = '0;

   localparam int DIR_ROWS     = 25;
   localparam int RANDOM_ITEMS = 1600;

   // Rows with typed set carry a result that is plain from the rules; the
   // rest are checked against the predictor.
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, NAME_ERROR},
      '{" ",   1'b1, 1'b1, NAME_BLANK},
      '{",",   1'b1, 1'b1, NAME_BLANK},
      '{"-",   1'b1, 1'b1, NAME_BLANK},
      '{8'hFF, 1'b1, 1'b1, NAME_ERROR},
      '{8'h9A, 1'b1, 1'b1, NAME_ERROR},
      '{"R",   1'b0, 1'b0, NO_CODE},
      '{"o",   1'b0, 1'b0, NO_CODE},
      '{"b",   1'b0, 1'b0, NO_CODE},
      '{"e",   1'b0, 1'b0, NO_CODE},
      '{"r",   1'b0, 1'b0, NO_CODE},
      '{"t",   1'b1, 1'b0, NO_CODE},
      '{"H",   1'b0, 1'b0, NO_CODE},
      '{"w",   1'b0, 1'b0, NO_CODE},
      '{"b",   1'b0, 1'b0, NO_CODE},
      '{8'hF1, 1'b1, 1'b0, NO_CODE},
      '{"z",   1'b0, 1'b0, NO_CODE},
      '{8'hE7, 1'b0, 1'b0, NO_CODE},
      '{8'h00, 1'b0, 1'b0, NO_CODE},
      '{"Q",   1'b1, 1'b0, NO_CODE},
      '{"A",   1'b0, 1'b0, NO_CODE},
      '{" ",   1'b0, 1'b0, NO_CODE},
      '{"t",   1'b0, 1'b0, NO_CODE},
      '{"d",   1'b0, 1'b0, NO_CODE},
      '{"l",   1'b1, 1'b0, NO_CODE}
   };

   logic       clock;
   logic       reset         = 1'b1;
   logic [7:0] req_char_code = 8'h00;
   logic       req_last      = 1'b0;
   logic       push          = 1'b0;
   logic       pop           = 1'b0;
   logic       full;
   logic [6:0] rsp_code_char0;
   logic [6:0] rsp_code_char1;
   logic [6:0] rsp_code_char2;
   logic [6:0] rsp_code_char3;
   logic       rsp_bad_name;
   logic       empty;

   soundex_name_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_char_code  (req_char_code),
      .req_last       (req_last),
      .push           (push),
      .full           (full),
      .rsp_code_char0 (rsp_code_char0),
      .rsp_code_char1 (rsp_code_char1),
      .rsp_code_char2 (rsp_code_char2),
      .rsp_code_char3 (rsp_code_char3),
      .rsp_bad_name   (rsp_bad_name),
      .empty          (empty),
      .pop            (pop)
   );

   // Name state of the predictor.
   logic [2:0]                    nm_codes;
   logic [sndx_pkg::CHARS_W-1:0]  nm_chars;
   logic [2:0]                    nm_prev;
   logic                          nm_ended;
   logic                          nm_err;
   logic [6:0]                    nm_lead;
   logic [2:0]                    nm_digits [3];

   soundex_type pending_codes [$];
   int       mismatches = 0;
   int       items_sent = 0;
   int       idle_odds  = 0;
   bit       quiet      = 1'b0;
   int       pop_hold   = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic void clear_name();
      nm_codes = '0;
      nm_chars = '0;
      nm_prev = sndx_pkg::CODE_NONE;
      nm_ended = 1'b0;
      nm_err = 1'b0;
      nm_lead = 7'("0");
      for (int i = 0; i < 3; i++) nm_digits[i] = sndx_pkg::CODE_NONE;
   endfunction

   function automatic logic [2:0] digit_code(input logic [7:0] c);
      case (c)
         "b", "f", "p", "v": return 3'd1;
         "c", "s", "g", "j", "k", "q", "x", "z", 8'h9A, 8'hE7: return 3'd2;
         "d", "t": return 3'd3;
         "l": return 3'd4;
         "m", "n", 8'hF1: return 3'd5;
         "r": return 3'd6;
         "h", "w": return sndx_pkg::CODE_SKIP;
         default: return sndx_pkg::CODE_NONE;
      endcase
   endfunction

   // Folds one byte into the name state; returns 1 with the code on the final beat.
   function automatic bit encode_byte(input logic [7:0] ch, input logic fin,
                                      output soundex_type res);
      logic [7:0] c;
      logic [2:0] code;
      c = ch;
      res = NO_CODE;
      if (!nm_ended && nm_chars < sndx_pkg::MAX_NAME_CHARS) begin
         if (c == 8'h00) begin
            nm_ended = 1'b1;
         end else begin
            nm_chars++;
            if (c >= "A" && c <= "Z") c = c + 8'd32;
            if (c == "," || c == "-") begin
               nm_ended = 1'b1;
            end else if (c != " ") begin
               code = digit_code(c);
               if (nm_codes == 0) begin
                  if (!(c >= "a" && c <= "z")) begin
                     nm_err = 1'b1;
                     nm_ended = 1'b1;
                  end else begin
                     nm_lead = 7'(c - 8'd32);
                     nm_codes = 3'd1;
                  end
               end else if (code != sndx_pkg::CODE_NONE &&
                            code != sndx_pkg::CODE_SKIP && code != nm_prev) begin
                  nm_digits[nm_codes - 1] = code;
                  nm_codes++;
                  if (nm_codes >= 4) nm_ended = 1'b1;
               end
               // h and w leave the previous code alone, so repeats across them drop.
               if (code != sndx_pkg::CODE_SKIP) nm_prev = code;
            end
         end
      end
      if (!fin) return 1'b0;
      if (nm_err || nm_chars == 0) begin
         res = NAME_ERROR;
      end else begin
         res.c0 = (nm_codes > 0) ? nm_lead : 7'("0");
         res.c1 = 7'("0") + 7'(nm_digits[0]);
         res.c2 = 7'("0") + 7'(nm_digits[1]);
         res.c3 = 7'("0") + 7'(nm_digits[2]);
         res.bad = 1'b0;
      end
      clear_name();
      return 1'b1;
   endfunction

   function automatic logic [7:0] name_char(input bit lead);
      int pick;
      pick = $urandom_range(0, 99);
      // A name always opens with a letter so that coding gets past the lead.
      if (lead && pick >= 15) pick = pick % 70;
      if (pick < 40) return 8'("a") + 8'($urandom_range(0, 25));
      if (pick < 70) return 8'("A") + 8'($urandom_range(0, 25));
      if (pick < 80) begin
         case ($urandom_range(0, 2))
            0: return 8'h9A;
            1: return 8'hE7;
            default: return 8'hF1;
         endcase
      end
      if (pick < 85) return " ";
      if (pick < 88) return ($urandom_range(0, 1) == 0) ? "," : "-";
      if (pick < 90) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_byte(input logic [7:0] ch, input logic fin, input logic typed,
                            input soundex_type typed_res);
      soundex_type res;
      if (!quiet && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_char_code <= ch;
      req_last <= fin;
      push <= 1'b1;
      do @(posedge clock); while (full);
      if (encode_byte(ch, fin, res)) pending_codes.push_back(typed ? typed_res : res);
      items_sent++;
   endtask

   task automatic drain_codes();
      push <= 1'b0;
      do @(posedge clock); while (pending_codes.size() != 0);
   endtask

   // Receiver: pop stalls come in bursts of random length.
   always @(posedge clock) begin
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         pop_hold <= $urandom_range(0, 18);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_codes
      soundex_type want;
      soundex_type got;
      if (!reset && pop && !empty) begin
         got = '{rsp_code_char0, rsp_code_char1, rsp_code_char2, rsp_code_char3,
                 rsp_bad_name};
         if (pending_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: got %c%c%c%c bad=%0d",
                        got.c0, got.c1, got.c2, got.c3, got.bad);
         end else begin
            want = pending_codes.pop_front();
            if (got.c0 !== want.c0 || got.c1 !== want.c1 || got.c2 !== want.c2 ||
                got.c3 !== want.c3 || got.bad !== want.bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("code mismatch: expected %c%c%c%c bad=%0d, got %c%c%c%c bad=%0d",
                           want.c0, want.c1, want.c2, want.c3, want.bad,
                           got.c0, got.c1, got.c2, got.c3, got.bad);
            end
         end
      end
   end

   initial begin : stimulus
      int  len;
      bit  noise;
      bit  drained;
      logic [7:0] ch;
      drained = 1'b0;
      clear_name();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TABLE[i])
         send_byte(DIR_TABLE[i].ch, DIR_TABLE[i].fin, DIR_TABLE[i].typed, DIR_TABLE[i].res);

      while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
         quiet = (items_sent >= DIR_ROWS + RANDOM_ITEMS - 200);
         if (!drained && items_sent >= DIR_ROWS + RANDOM_ITEMS / 2) begin
            drain_codes();
            drained = 1'b1;
         end
         case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 4;
            default: idle_odds = 16;
         endcase
         noise = ($urandom_range(0, 9) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            ch = noise ? 8'($urandom_range(0, 255)) : name_char(i == 0);
            send_byte(ch, i == len - 1, 1'b0, NO_CODE);
         end
      end

      drain_codes();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_codes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
